// ----- src/hmac_sha256_engine_unit_defines.svh -----
// Assertion helpers shared by the engine modules
`ifndef HMAC_SHA256_ENGINE_UNIT_DEFINES_SVH
`define HMAC_SHA256_ENGINE_UNIT_DEFINES_SVH

// Check an implication on every clock edge outside reset
`define HSE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication including the reset cycles
`define HSE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/hse_pkg.sv -----
`default_nettype none
package hse_pkg;

  localparam int KEY_BYTES_DEF = 32;
  localparam int KEY_REGS = 4;
  localparam int CFG_IDX_W = 2;
  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } out_item_t;

  // Front-to-back queue entry: a byte, its last mark and a first-of-message mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } q_item_t;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;
  typedef logic [15:0][31:0] block_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_t;

  localparam hash_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- src/hse_front.sv -----
`default_nettype none
`include "hmac_sha256_engine_unit_defines.svh"
// Accepts message bytes, tags the first byte of each message, queues them
module hse_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire hse_pkg::in_item_t in_data,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output hse_pkg::q_item_t      q_data
);
  localparam int DEPTH = hse_pkg::FIFO_DEPTH;
  localparam int AW = $clog2(DEPTH);

  hse_pkg::q_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          first_r;
  logic          push, pop;

  assign in_ready = (cnt_r != DEPTH[AW:0]);
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{data: in_data.msg_byte, last: in_data.last_byte, first: first_r};
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      first_r <= 1'b1;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
        first_r <= in_data.last_byte;
      end
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
    end
  end

  `HSE_ASSERT(a_no_overflow, clk, rst_n, cnt_r <= DEPTH[AW:0], "queue overflow")
  `HSE_ASSERT(a_pop_nonempty, clk, rst_n, pop |-> cnt_r != '0, "pop from empty queue")
  `HSE_ASSERT(a_cnt_track, clk, rst_n, (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1,
              "queue count lost a push")
endmodule
`default_nettype wire

// ----- src/hse_round.sv -----
`default_nettype none
`include "hmac_sha256_engine_unit_defines.svh"
// SHA-256 compression: one round per cycle, message schedule in a 16-word window
module hse_round (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire hse_pkg::hash_t h_in,
  input  wire hse_pkg::block_t blk_in,
  output logic               busy,
  output logic               done,
  output hse_pkg::hash_t     h_out
);
  hse_pkg::hash_t  v_r, h_r;
  hse_pkg::block_t w_r;
  logic [5:0] rnd_r;
  logic       busy_r, done_r;
  hse_pkg::word_t t1, t2, wn, s0, s1, e, a;
  hse_pkg::hash_t fin, vn;

  always_comb begin
    a = v_r[0];
    e = v_r[4];
    t1 = v_r[7] + (hse_pkg::rotr(e, 6) ^ hse_pkg::rotr(e, 11) ^ hse_pkg::rotr(e, 25))
         + ((e & v_r[5]) ^ (~e & v_r[6])) + hse_pkg::round_k(rnd_r) + w_r[0];
    t2 = (hse_pkg::rotr(a, 2) ^ hse_pkg::rotr(a, 13) ^ hse_pkg::rotr(a, 22))
         + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    s0 = hse_pkg::rotr(w_r[1], 7) ^ hse_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = hse_pkg::rotr(w_r[14], 17) ^ hse_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = s1 + w_r[9] + s0 + w_r[0];
    vn = {v_r[6:4], v_r[3] + t1, v_r[2:0], t1 + t2};
    // fold in the working state after the final round
    for (int i = 0; i < 8; i++) fin[i] = h_r[i] + vn[i];
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign h_out = h_r;

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= h_in;
      h_r <= h_in;
      w_r <= blk_in;
    end else if (busy_r) begin
      v_r <= vn;
      w_r <= {wn, w_r[15:1]};
      if (rnd_r == 6'd63) h_r <= fin;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 1'b1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  `HSE_ASSERT(a_start_idle, clk, rst_n, start |-> !busy_r, "compression restarted while busy")
  `HSE_ASSERT(a_done_end, clk, rst_n, done_r |-> $past(rnd_r) == 6'd63, "early done")
endmodule
`default_nettype wire

// ----- src/hse_back.sv -----
`default_nettype none
`include "hmac_sha256_engine_unit_defines.svh"
// Sequencer: block assembly, padding, inner and outer hash, digest emission
module hse_back #(
  parameter int KEY_BYTES = hse_pkg::KEY_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire hse_pkg::q_item_t      q_data,
  input  wire logic [3:0][63:0]      key,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output hse_pkg::out_item_t         out_data
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_IPAD  = 9'b000000010,
    S_TAKE  = 9'b000000100,
    S_BLK   = 9'b000001000,
    S_PAD1  = 9'b000010000,
    S_PAD2  = 9'b000100000,
    S_OPAD  = 9'b001000000,
    S_OUTER = 9'b010000000,
    S_EMIT  = 9'b100000000
  } st_t;

  st_t st_r, st_nxt;
  hse_pkg::hash_t  chain_r, inner_r;
  hse_pkg::block_t blk_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic        last_r;
  logic [4:0]  ocnt_r;
  logic        start;
  hse_pkg::hash_t  h_in, h_out;
  hse_pkg::block_t blk_in, keyblk;
  logic        busy, done;
  logic [7:0]  pad_sel;

  hse_round u_round (
    .clk(clk), .rst_n(rst_n), .start(start), .h_in(h_in), .blk_in(blk_in),
    .busy(busy), .done(done), .h_out(h_out)
  );

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      logic [7:0] kb;
      kb = 8'h00;
      if (i < 32 && i < KEY_BYTES) kb = key[i/8][8*(7-(i%8)) +: 8];
      keyblk[15 - i/4][8*(3-(i%4)) +: 8] = kb ^ pad_sel;
    end
  end
  assign pad_sel = (st_r == S_OPAD) ? hse_pkg::OPAD : hse_pkg::IPAD;

  // Words are kept with word 0 at index 0 so the schedule shifts down
  hse_pkg::block_t blk_words, keyw;
  always_comb begin
    for (int i = 0; i < 16; i++) keyw[i] = keyblk[15-i];
  end

  logic at_start;
  assign at_start = (st_r == S_IPAD || st_r == S_BLK || st_r == S_PAD1 || st_r == S_PAD2 ||
                     st_r == S_OPAD || st_r == S_OUTER) && !busy && !done;

  logic launched_r;
  assign start = at_start && !launched_r;

  always_comb begin
    h_in = chain_r;
    blk_words = blk_r;
    unique case (st_r)
      S_IPAD, S_OPAD: begin
        h_in = hse_pkg::INIT_H;
        blk_words = keyw;
      end
      S_OUTER: begin
        for (int i = 0; i < 8; i++) blk_words[i] = inner_r[i];
        blk_words[8] = 32'h80000000;
        for (int i = 9; i < 15; i++) blk_words[i] = '0;
        blk_words[15] = 32'd768;
      end
      default: ;
    endcase
  end
  assign blk_in = blk_words;

  assign q_ready = (st_r == S_TAKE);
  assign out_valid = (st_r == S_EMIT);
  assign out_data = '{digest_byte: chain_r[ocnt_r[4:2]][8*(3-ocnt_r[1:0]) +: 8],
                      digest_last: (ocnt_r == 5'd31)};

  // padding room: 0x80 plus length must fit after the fill
  logic [5:0] nfill;
  logic       take;
  assign take = q_valid && q_ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (q_valid) st_nxt = q_data.first ? S_IPAD : S_TAKE;
      S_IPAD:  if (done) st_nxt = S_TAKE;
      S_TAKE:  if (take) begin
        if (fill_r == 6'd63) st_nxt = S_BLK;
        else if (q_data.last) st_nxt = S_PAD1;
        else st_nxt = S_IDLE;
      end
      S_BLK:   if (done) st_nxt = last_r ? S_PAD1 : S_IDLE;
      S_PAD1:  if (done) st_nxt = (fill_r >= 6'd56) ? S_PAD2 : S_OPAD;
      S_PAD2:  if (done) st_nxt = S_OPAD;
      S_OPAD:  if (done) st_nxt = S_OUTER;
      S_OUTER: if (done) st_nxt = S_EMIT;
      S_EMIT:  if (out_ready && ocnt_r == 5'd31) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end
  assign nfill = fill_r + 1'b1;

  // Build the final block(s) in place before PAD1 launches
  function automatic hse_pkg::block_t put_byte(input hse_pkg::block_t b,
                                               input logic [5:0] p, input logic [7:0] d);
    hse_pkg::block_t r;
    r = b;
    r[p[5:2]][8*(3-p[1:0]) +: 8] = d;
    return r;
  endfunction

  function automatic hse_pkg::block_t pad_blk(input hse_pkg::block_t b,
                                              input logic [5:0] f, input logic [63:0] n);
    hse_pkg::block_t r;
    r = b;
    for (int i = 0; i < 64; i++) begin
      if (i == f) r[i/4][8*(3-(i%4)) +: 8] = hse_pkg::PAD_BYTE;
      else if (i > f) r[i/4][8*(3-(i%4)) +: 8] = 8'h00;
    end
    if (f < 6'd56) begin
      r[14] = n[63:32];
      r[15] = n[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      chain_r <= hse_pkg::INIT_H;
      fill_r <= '0;
      bits_r <= '0;
      last_r <= 1'b0;
      ocnt_r <= '0;
      launched_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (start) launched_r <= 1'b1;
      if (done) launched_r <= 1'b0;
      unique case (st_r)
        S_IDLE: ;
        S_IPAD: if (done) begin
          chain_r <= h_out;
          bits_r <= 64'd512;
          fill_r <= '0;
        end
        S_TAKE: if (take) begin
          fill_r <= nfill;
          bits_r <= bits_r + 64'd8;
          last_r <= q_data.last;
          if (q_data.last && fill_r != 6'd63)
            blk_r <= pad_blk(put_byte(blk_r, fill_r, q_data.data), nfill, bits_r + 64'd8);
          else
            blk_r <= put_byte(blk_r, fill_r, q_data.data);
        end
        S_BLK: if (done) begin
          chain_r <= h_out;
          fill_r <= '0;
          if (last_r) blk_r <= pad_blk(blk_r, 6'd0, bits_r);
        end
        S_PAD1: if (done) begin
          chain_r <= h_out;
          // length alone in a block of zeros
          if (fill_r >= 6'd56) blk_r <= {bits_r[31:0], bits_r[63:32], 448'd0};
        end
        S_PAD2: if (done) chain_r <= h_out;
        // hold the inner digest aside, carry on from the outer key state
        S_OPAD: if (done) begin
          inner_r <= chain_r;
          chain_r <= h_out;
        end
        S_OUTER: if (done) begin
          chain_r <= h_out;
          ocnt_r <= '0;
        end
        S_EMIT: if (out_ready) begin
          ocnt_r <= ocnt_r + 1'b1;
          if (ocnt_r == 5'd31) begin
            chain_r <= hse_pkg::INIT_H;
            fill_r <= '0;
            bits_r <= '0;
            last_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `HSE_ASSERT(a_take_only, clk, rst_n, take |-> st_r == S_TAKE, "byte taken outside take state")
  `HSE_ASSERT(a_emit_nostart, clk, rst_n, (st_r == S_EMIT) |-> !busy, "emit while hashing")
endmodule
`default_nettype wire

// ----- src/hmac_sha256_engine_unit.sv -----
`default_nettype none
`include "hmac_sha256_engine_unit_defines.svh"
// HMAC-SHA256 engine, 32-byte key from four 64-bit registers.
// Input channel in_valid/in_ready/in_data carries one message byte per request,
// with last_byte on the final one; messages hold at least one byte.
// A front queue of four entries takes bytes while the back hashes.
// Key registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data
// by the user only while the engine is idle; the block itself does not
// enforce this. cfg_ready is always high. Each compression runs 64 rounds
// on one shared round unit. The back classifies every byte, then takes it.
// The first byte of a message waits for the inner key block to be hashed.
// After the last byte come one or two padding compressions (two when that
// byte completes a block or leaves 56 or more bytes in it) and two for the
// outer hash; then the 32 digest bytes leave on out_valid/out_ready at one
// per cycle while out_ready is high, byte 0 first, digest_last on the 32nd.
// A stalled receiver holds the current digest byte; input then backs up
// once the queue is full. Reset (rst_n low, synchronous) clears the keys
// to zero, empties the queue and rearms for a new message.
module hmac_sha256_engine_unit #(
  parameter int KEY_BYTES = hse_pkg::KEY_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire hse_pkg::in_item_t      in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output hse_pkg::out_item_t          out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [hse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]            cfg_data
);
  logic [3:0][63:0] key_r;
  logic             q_valid, q_ready;
  hse_pkg::q_item_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) key_r <= '0;
    else if (cfg_valid) begin
      unique case (hse_pkg::reg_idx_t'(cfg_index))
        hse_pkg::REG_KEY0: key_r[0] <= cfg_data;
        hse_pkg::REG_KEY1: key_r[1] <= cfg_data;
        hse_pkg::REG_KEY2: key_r[2] <= cfg_data;
        hse_pkg::REG_KEY3: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  hse_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  hse_back #(.KEY_BYTES(KEY_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .key(key_r), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  `HSE_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid,
              "digest dropped while stalled")
endmodule
`default_nettype wire
